// ===== sv/hold_to_secondary_click_filter_core_defines.svh =====
// assertion macros for the hold-to-secondary click filter
// used by the top level only, expects clk and rst_n in scope
`ifndef HOLD_TO_SECONDARY_CLICK_FILTER_CORE_DEFINES_SVH
`define HOLD_TO_SECONDARY_CLICK_FILTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define HSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsc assertion failed");
`define HSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsc assertion failed");
`else
`define HSC_ASSERT_IMP(lbl, ante, cons)
`define HSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/hsc_pkg.sv =====
// shared types, codes and result builders for the click filter
// no dependencies
package hsc_pkg;

  localparam logic [1:0] OP_NONPTR  = 2'd0;
  localparam logic [1:0] OP_POINTER = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic [1:0] ACT_DOWN   = 2'd0;
  localparam logic [1:0] ACT_UP     = 2'd1;
  localparam logic [1:0] ACT_MOTION = 2'd2;
  localparam logic [1:0] ACT_OTHER  = 2'd3;

  localparam logic [4:0] BTN_PRIMARY   = 5'd1;
  localparam logic [4:0] BTN_SECONDARY = 5'd2;

  localparam logic [2:0] KIND_PASS          = 3'd0;
  localparam logic [2:0] KIND_CONSUME       = 3'd1;
  localparam logic [2:0] KIND_REPLAY_PRESS  = 3'd2;
  localparam logic [2:0] KIND_REPLAY_MOTION = 3'd3;
  localparam logic [2:0] KIND_SYN_DOWN      = 3'd4;
  localparam logic [2:0] KIND_SYN_UP        = 3'd5;
  localparam logic [2:0] KIND_TICK_DONE     = 3'd6;

  localparam logic [1:0] NOTICE_NONE       = 2'd0;
  localparam logic [1:0] NOTICE_HOLD_START = 2'd1;
  localparam logic [1:0] NOTICE_CANCEL     = 2'd2;
  localparam logic [1:0] NOTICE_CLICK      = 2'd3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_HELD = 2'd1;
  localparam logic [1:0] MODE_DRAG = 2'd2;

  localparam logic [1:0] CFG_HOLD_TICKS  = 2'd0;
  localparam logic [1:0] CFG_VIRTUAL_DEV = 2'd1;

  localparam logic [15:0] HOLD_TICKS_RESET  = 16'd1000;
  localparam logic [7:0]  VIRTUAL_DEV_RESET = 8'd255;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         action;
    logic [4:0]         buttons;
    logic [7:0]         dev_id;
    logic [47:0]        stamp;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] rel_x;
    logic signed [15:0] rel_y;
    logic [15:0]        modifiers;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_kind;
    logic [1:0]         out_action;
    logic [4:0]         out_buttons;
    logic [7:0]         out_dev_id;
    logic [47:0]        out_stamp;
    logic signed [15:0] out_pos_x;
    logic signed [15:0] out_pos_y;
    logic signed [15:0] out_rel_x;
    logic signed [15:0] out_rel_y;
    logic [15:0]        out_modifiers;
    logic [1:0]         notice;
    logic               last_result;
  } out_item_t;

  // up to three results caused by one input item
  typedef struct packed {
    logic [1:0]          count;
    out_item_t [2:0]     slot;
  } batch_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       pending;
  } filt_status_t;

  function automatic out_item_t echo_item(logic [2:0] kind, in_item_t it,
                                          logic [1:0] note);
    out_item_t r;
    r.out_kind       = kind;
    r.out_action     = it.action;
    r.out_buttons    = it.buttons;
    r.out_dev_id     = it.dev_id;
    r.out_stamp      = it.stamp;
    r.out_pos_x      = it.pos_x;
    r.out_pos_y      = it.pos_y;
    r.out_rel_x      = it.rel_x;
    r.out_rel_y      = it.rel_y;
    r.out_modifiers  = it.modifiers;
    r.notice         = note;
    r.last_result    = 1'b0;
    return r;
  endfunction

  function automatic out_item_t synth_item(logic down, logic [4:0] btn,
                                           logic [7:0] vdev, logic [1:0] note);
    out_item_t r;
    r               = '0;
    r.out_kind      = down ? KIND_SYN_DOWN : KIND_SYN_UP;
    r.out_action    = down ? ACT_DOWN : ACT_UP;
    r.out_buttons   = down ? btn : 5'd0;
    r.out_dev_id    = vdev;
    r.notice        = note;
    return r;
  endfunction

  function automatic out_item_t tick_item();
    out_item_t r;
    r          = '0;
    r.out_kind = KIND_TICK_DONE;
    return r;
  endfunction

endpackage

// ===== sv/hold_to_secondary_click_filter_core.sv =====
// top level of the hold-to-secondary click filter
// depends on hsc_pkg, hsc_filter_fsm, hsc_out_queue and the assertion header
//
//  channel | ports                               | transfer when
//  --------+-------------------------------------+-------------------------
//  input   | in_valid, in_ready, in_data         | in_valid & in_ready
//  result  | out_valid, out_ready, out_data      | out_valid & out_ready
//  config  | cfg_we, cfg_index, cfg_wdata        | cfg_we (no wait)
//
// an input item is taken into the input register, decided in one pass once
// the result register can take a fresh batch, and its one to three results
// are loaded into the result register; results leave one per cycle while
// out_ready is high, so the result port sets the pace
// a new item is taken while the previous batch drains; in_ready drops only
// when the input register holds an item and the result register is still busy
// reset (synchronous, rst_n low) clears mode, countdown and both valid stages
`include "hold_to_secondary_click_filter_core_defines.svh"

module hold_to_secondary_click_filter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsc_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  // configuration registers
  logic [15:0] hold_ticks_r;
  logic [7:0]  virtual_dev_r;

  // input register
  hsc_pkg::in_item_t     in_r;
  logic                  in_v_r;

  hsc_pkg::batch_t       batch;
  hsc_pkg::filt_status_t status;
  logic                  can_load;
  logic                  issue;

  // decision fires once the result register can take a fresh batch
  assign issue    = in_v_r && can_load;
  assign in_ready = !in_v_r || issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r  <= hsc_pkg::HOLD_TICKS_RESET;
      virtual_dev_r <= hsc_pkg::VIRTUAL_DEV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsc_pkg::CFG_HOLD_TICKS:  hold_ticks_r  <= cfg_wdata;
        hsc_pkg::CFG_VIRTUAL_DEV: virtual_dev_r <= cfg_wdata[7:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (issue) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  hsc_filter_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (in_r),
    .issue      (issue),
    .hold_ticks (hold_ticks_r),
    .vdev_id    (virtual_dev_r),
    .batch      (batch),
    .status     (status)
  );

  hsc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (issue),
    .batch     (batch),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a pending countdown only exists while the press is withheld
  `HSC_ASSERT_IMP(a_pending_only_held, status.pending, status.mode == hsc_pkg::MODE_HELD)
  // a decided item always shows a result on the next cycle
  `HSC_ASSERT_NEXT(a_issue_shows_result, issue, out_valid)
  // results of one item follow without a gap
  `HSC_ASSERT_NEXT(a_batch_no_gap, out_valid && out_ready && !out_data.last_result, out_valid)

endmodule

// ===== sv/hsc_filter_fsm.sv =====
// filter state and per-item decision: builds the batch of results
// depends on hsc_pkg
module hsc_filter_fsm (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hsc_pkg::in_item_t      item,
  input  logic                   issue,
  input  logic [15:0]            hold_ticks,
  input  logic [7:0]             vdev_id,
  output hsc_pkg::batch_t        batch,
  output hsc_pkg::filt_status_t  status
);

  logic [1:0]  mode_r, mode_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [15:0] rem_dec;
  logic        save_en;

  // saved press, only read in held mode which is entered by writing it
  hsc_pkg::in_item_t saved_r;

  always_comb begin
    mode_nxt      = mode_r;
    pending_nxt   = pending_r;
    remaining_nxt = remaining_r;
    save_en       = 1'b0;
    batch         = '0;
    batch.count   = 2'd1;
    rem_dec       = (remaining_r != 16'd0) ? remaining_r - 16'd1 : remaining_r;

    if (item.operation == hsc_pkg::OP_TICK) begin
      batch.slot[0] = hsc_pkg::tick_item();
      if (pending_r) begin
        remaining_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          pending_nxt   = 1'b0;
          batch.count   = 2'd3;
          batch.slot[0] = hsc_pkg::synth_item(1'b1, hsc_pkg::BTN_SECONDARY,
                                              vdev_id, hsc_pkg::NOTICE_CLICK);
          batch.slot[1] = hsc_pkg::synth_item(1'b0, 5'd0, vdev_id,
                                              hsc_pkg::NOTICE_NONE);
          batch.slot[2] = hsc_pkg::tick_item();
        end
      end
    end else if (item.operation != hsc_pkg::OP_POINTER ||
                 item.dev_id == vdev_id) begin
      batch.slot[0] = hsc_pkg::echo_item(hsc_pkg::KIND_PASS, item, hsc_pkg::NOTICE_NONE);
    end else begin
      batch.slot[0] = hsc_pkg::echo_item(hsc_pkg::KIND_PASS, item, hsc_pkg::NOTICE_NONE);
      unique case (mode_r)
        hsc_pkg::MODE_HELD: begin
          if (item.action == hsc_pkg::ACT_MOTION) begin
            // replay the withheld press at the motion's time, then the motion
            batch.count                    = 2'd3;
            batch.slot[0]                  = hsc_pkg::echo_item(
                hsc_pkg::KIND_REPLAY_PRESS, saved_r,
                pending_r ? hsc_pkg::NOTICE_CANCEL : hsc_pkg::NOTICE_NONE);
            batch.slot[0].out_action       = hsc_pkg::ACT_DOWN;
            batch.slot[0].out_stamp        = item.stamp;
            batch.slot[1] = hsc_pkg::echo_item(hsc_pkg::KIND_REPLAY_MOTION, item,
                                               hsc_pkg::NOTICE_NONE);
            batch.slot[2] = hsc_pkg::echo_item(hsc_pkg::KIND_CONSUME, item,
                                               hsc_pkg::NOTICE_NONE);
            pending_nxt   = 1'b0;
            mode_nxt      = hsc_pkg::MODE_DRAG;
          end else if (item.action == hsc_pkg::ACT_UP && !item.buttons[0]) begin
            if (pending_r) begin
              batch.count   = 2'd3;
              batch.slot[0] = hsc_pkg::synth_item(1'b1, hsc_pkg::BTN_PRIMARY,
                                                  vdev_id, hsc_pkg::NOTICE_CANCEL);
              batch.slot[1] = hsc_pkg::synth_item(1'b0, 5'd0, vdev_id,
                                                  hsc_pkg::NOTICE_NONE);
              batch.slot[2] = hsc_pkg::echo_item(hsc_pkg::KIND_PASS, item,
                                                 hsc_pkg::NOTICE_NONE);
            end
            pending_nxt = 1'b0;
            mode_nxt    = hsc_pkg::MODE_IDLE;
          end
        end
        hsc_pkg::MODE_DRAG: begin
          if (item.action == hsc_pkg::ACT_UP) begin
            mode_nxt = hsc_pkg::MODE_IDLE;
          end
        end
        default: begin
          if (item.action == hsc_pkg::ACT_DOWN && item.buttons[0]) begin
            save_en       = 1'b1;
            pending_nxt   = 1'b1;
            remaining_nxt = hold_ticks;
            mode_nxt      = hsc_pkg::MODE_HELD;
            batch.slot[0] = hsc_pkg::echo_item(hsc_pkg::KIND_CONSUME, item,
                                               hsc_pkg::NOTICE_HOLD_START);
          end
        end
      endcase
    end

    case (batch.count)
      2'd3:    batch.slot[2].last_result = 1'b1;
      2'd2:    batch.slot[1].last_result = 1'b1;
      default: batch.slot[0].last_result = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= hsc_pkg::MODE_IDLE;
      pending_r   <= 1'b0;
      remaining_r <= 16'd0;
    end else if (issue) begin
      mode_r      <= mode_nxt;
      pending_r   <= pending_nxt;
      remaining_r <= remaining_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && save_en) begin
      saved_r <= item;
    end
  end

  assign status.mode    = mode_r;
  assign status.pending = pending_r;

endmodule

// ===== sv/hsc_out_queue.sv =====
// result register: holds one batch and hands it out one result per cycle while out_ready is high
// depends on hsc_pkg
module hsc_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  hsc_pkg::batch_t     batch,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output hsc_pkg::out_item_t  out_data
);

  hsc_pkg::out_item_t [2:0] slots_r;
  logic [1:0]               count_r;
  logic [1:0]               idx_r;
  logic                     take;
  logic                     last_take;

  assign out_valid = (count_r != 2'd0);
  assign take      = out_valid && out_ready;
  assign last_take = take && (idx_r == count_r - 2'd1);
  assign can_load  = !out_valid || last_take;
  assign out_data  = slots_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      idx_r   <= 2'd0;
    end else if (load) begin
      count_r <= batch.count;
      idx_r   <= 2'd0;
    end else if (last_take) begin
      count_r <= 2'd0;
      idx_r   <= 2'd0;
    end else if (take) begin
      idx_r   <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots_r <= batch.slot;
    end
  end

endmodule

// ===== test/tb_hold_to_secondary_click_filter_core.sv =====
// testbench for hold_to_secondary_click_filter_core: directed and random pointer traffic,
// results checked against a cycle-free model of the filter kept in this file
// depends on hsc_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_hold_to_secondary_click_filter_core;

  // operation code that the block does not define, passes like a non-pointer event
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 100;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  hsc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hsc_pkg::out_item_t out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  hold_to_secondary_click_filter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // filter model: its own copy of the registers and the gesture state
  // ---------------------------------------------------------------------------
  logic [15:0] hold_cfg = hsc_pkg::HOLD_TICKS_RESET;
  logic [7:0]  vdev_cfg = hsc_pkg::VIRTUAL_DEV_RESET;
  logic [1:0]  filt_mode = hsc_pkg::MODE_IDLE;
  logic        hold_pending = 1'b0;
  logic [15:0] hold_left = '0;
  hsc_pkg::in_item_t held_press = '0;  // only read once a press has been stored

  hsc_pkg::in_item_t  events_to_send[$];  // filled by the sequencer, drained by the driver
  hsc_pkg::out_item_t results_due[$];     // oldest expected result first
  int queued_total = 0;
  int accepted_total = 0;
  int errors = 0;

  // idle odds per phase: zero means no idling, n means one chance in n per slot
  int  idle_odds = 4;
  logic hold_off_req = 1'b0;

  function automatic hsc_pkg::out_item_t emitted(logic [2:0] kind, logic [1:0] act,
                                                 logic [4:0] btn, logic [7:0] dev,
                                                 logic [47:0] stamp, logic [15:0] px,
                                                 logic [15:0] py, logic [15:0] rx,
                                                 logic [15:0] ry, logic [15:0] mods,
                                                 logic [1:0] note);
    hsc_pkg::out_item_t r;
    r.out_kind       = kind;
    r.out_action     = act;
    r.out_buttons    = btn;
    r.out_dev_id     = dev;
    r.out_stamp      = stamp;
    r.out_pos_x      = px;
    r.out_pos_y      = py;
    r.out_rel_x      = rx;
    r.out_rel_y      = ry;
    r.out_modifiers  = mods;
    r.notice         = note;
    r.last_result    = 1'b0;
    return r;
  endfunction

  // the event as it came in, tagged with a kind
  function automatic hsc_pkg::out_item_t copy_of(logic [2:0] kind, hsc_pkg::in_item_t ev,
                                                 logic [1:0] note);
    return emitted(kind, ev.action, ev.buttons, ev.dev_id, ev.stamp, ev.pos_x,
                   ev.pos_y, ev.rel_x, ev.rel_y, ev.modifiers, note);
  endfunction

  // generated click halves: virtual device, everything else zero, up has no buttons
  function automatic hsc_pkg::out_item_t synthetic(logic down, logic [4:0] btn,
                                                   logic [1:0] note);
    return emitted(down ? hsc_pkg::KIND_SYN_DOWN : hsc_pkg::KIND_SYN_UP,
                   down ? hsc_pkg::ACT_DOWN : hsc_pkg::ACT_UP,
                   down ? btn : 5'd0, vdev_cfg, '0, '0, '0, '0, '0, '0, note);
  endfunction

  // advance the model by one accepted event and queue the results it causes
  task automatic filter_step(input hsc_pkg::in_item_t ev);
    hsc_pkg::out_item_t res [3];
    int n;
    logic [1:0] note;
    n = 0;
    if (ev.operation == hsc_pkg::OP_TICK) begin
      // countdown fires on the tick that brings it to zero, zero or one fire at once
      if (hold_pending) begin
        if (hold_left != 0) hold_left = hold_left - 16'd1;
        if (hold_left == 0) begin
          hold_pending = 1'b0;
          res[0] = synthetic(1'b1, hsc_pkg::BTN_SECONDARY, hsc_pkg::NOTICE_CLICK);
          res[1] = synthetic(1'b0, hsc_pkg::BTN_SECONDARY, hsc_pkg::NOTICE_NONE);
          n = 2;
        end
      end
      res[n] = emitted(hsc_pkg::KIND_TICK_DONE, '0, '0, '0, '0, '0, '0, '0, '0, '0,
                       hsc_pkg::NOTICE_NONE);
      n++;
    end else if (ev.operation != hsc_pkg::OP_POINTER || ev.dev_id == vdev_cfg) begin
      // non-pointer, spare operation code and virtual device traffic bypass
      res[0] = copy_of(hsc_pkg::KIND_PASS, ev, hsc_pkg::NOTICE_NONE);
      n = 1;
    end else if (filt_mode == hsc_pkg::MODE_HELD) begin
      if (ev.action == hsc_pkg::ACT_MOTION) begin
        // drag: replay the stored press at the motion's time, then the motion
        note = hold_pending ? hsc_pkg::NOTICE_CANCEL : hsc_pkg::NOTICE_NONE;
        hold_pending = 1'b0;
        res[0] = emitted(hsc_pkg::KIND_REPLAY_PRESS, hsc_pkg::ACT_DOWN, held_press.buttons,
                         held_press.dev_id, ev.stamp, held_press.pos_x, held_press.pos_y,
                         held_press.rel_x, held_press.rel_y, held_press.modifiers, note);
        res[1] = copy_of(hsc_pkg::KIND_REPLAY_MOTION, ev, hsc_pkg::NOTICE_NONE);
        res[2] = copy_of(hsc_pkg::KIND_CONSUME, ev, hsc_pkg::NOTICE_NONE);
        n = 3;
        filt_mode = hsc_pkg::MODE_DRAG;
      end else if (ev.action == hsc_pkg::ACT_UP &&
                   (ev.buttons & hsc_pkg::BTN_PRIMARY) == 0) begin
        // early release adds a primary click ahead of the release, late release just passes
        if (hold_pending) begin
          res[0] = synthetic(1'b1, hsc_pkg::BTN_PRIMARY, hsc_pkg::NOTICE_CANCEL);
          res[1] = synthetic(1'b0, hsc_pkg::BTN_PRIMARY, hsc_pkg::NOTICE_NONE);
          n = 2;
        end
        hold_pending = 1'b0;
        filt_mode = hsc_pkg::MODE_IDLE;
        res[n] = copy_of(hsc_pkg::KIND_PASS, ev, hsc_pkg::NOTICE_NONE);
        n++;
      end else begin
        res[0] = copy_of(hsc_pkg::KIND_PASS, ev, hsc_pkg::NOTICE_NONE);
        n = 1;
      end
    end else if (filt_mode == hsc_pkg::MODE_DRAG) begin
      if (ev.action == hsc_pkg::ACT_UP) filt_mode = hsc_pkg::MODE_IDLE;
      res[0] = copy_of(hsc_pkg::KIND_PASS, ev, hsc_pkg::NOTICE_NONE);
      n = 1;
    end else if (ev.action == hsc_pkg::ACT_DOWN &&
                 (ev.buttons & hsc_pkg::BTN_PRIMARY) != 0) begin
      // primary press is withheld and the countdown armed
      held_press = ev;
      hold_pending = 1'b1;
      hold_left = hold_cfg;
      filt_mode = hsc_pkg::MODE_HELD;
      res[0] = copy_of(hsc_pkg::KIND_CONSUME, ev, hsc_pkg::NOTICE_HOLD_START);
      n = 1;
    end else begin
      res[0] = copy_of(hsc_pkg::KIND_PASS, ev, hsc_pkg::NOTICE_NONE);
      n = 1;
    end
    res[n-1].last_result = 1'b1;
    for (int i = 0; i < n; i++) results_due.push_back(res[i]);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued events, random gaps between transfers
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      // model update and accept count move together so the sequencer sees both
      if (in_valid && in_ready) begin
        filter_step(in_data);
        accepted_total++;
      end
      // payload may only change once the current one is gone
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (events_to_send.size() != 0 && idle_odds != 0 &&
                     $urandom_range(1, idle_odds) == 1) begin
          send_gap <= $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (events_to_send.size() != 0) begin
          in_data  <= events_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts plus one long hold-off to back up the block
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  int   long_left = 0;
  logic hold_off_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      long_left <= 0;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
      out_ready <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      hold_off_done <= 1'b1;
      long_left <= LONG_HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  hsc_pkg::out_item_t want;

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result with none expected: kind %0h", out_data.out_kind);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("out_kind", 48'(want.out_kind), 48'(out_data.out_kind));
        check_field("out_action", 48'(want.out_action), 48'(out_data.out_action));
        check_field("out_buttons", 48'(want.out_buttons), 48'(out_data.out_buttons));
        check_field("out_dev_id", 48'(want.out_dev_id), 48'(out_data.out_dev_id));
        check_field("out_stamp", want.out_stamp, out_data.out_stamp);
        check_field("out_pos_x", 48'(want.out_pos_x), 48'(out_data.out_pos_x));
        check_field("out_pos_y", 48'(want.out_pos_y), 48'(out_data.out_pos_y));
        check_field("out_rel_x", 48'(want.out_rel_x), 48'(out_data.out_rel_x));
        check_field("out_rel_y", 48'(want.out_rel_y), 48'(out_data.out_rel_y));
        check_field("out_modifiers", 48'(want.out_modifiers), 48'(out_data.out_modifiers));
        check_field("notice", 48'(want.notice), 48'(out_data.notice));
        check_field("last_result", 48'(want.last_result), 48'(out_data.last_result));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // event builders
  // ---------------------------------------------------------------------------
  function automatic hsc_pkg::in_item_t mk(logic [1:0] op, logic [1:0] act, logic [4:0] btn,
                                           logic [7:0] dev, logic [47:0] stamp,
                                           logic [15:0] px, logic [15:0] py,
                                           logic [15:0] rx, logic [15:0] ry,
                                           logic [15:0] mods);
    hsc_pkg::in_item_t e;
    e.operation  = op;
    e.action     = act;
    e.buttons    = btn;
    e.dev_id     = dev;
    e.stamp      = stamp;
    e.pos_x      = px;
    e.pos_y      = py;
    e.rel_x      = rx;
    e.rel_y      = ry;
    e.modifiers  = mods;
    return e;
  endfunction

  // any device but the virtual one
  function automatic logic [7:0] real_device();
    logic [7:0] d;
    d = 8'($urandom);
    while (d == vdev_cfg) d = 8'($urandom);
    return d;
  endfunction

  function automatic hsc_pkg::in_item_t ptr_evt(logic [1:0] act, logic [4:0] btn);
    return mk(hsc_pkg::OP_POINTER, act, btn, real_device(), {16'($urandom), 32'($urandom)},
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic logic [4:0] press_buttons();
    return 5'($urandom) | hsc_pkg::BTN_PRIMARY;
  endfunction

  function automatic logic [4:0] release_buttons();
    return 5'($urandom) & ~hsc_pkg::BTN_PRIMARY;
  endfunction

  // fully random, spare operation code and virtual device included
  function automatic hsc_pkg::in_item_t noise_event();
    hsc_pkg::in_item_t e;
    e = ptr_evt(2'($urandom), 5'($urandom));
    e.operation = 2'($urandom);
    if ($urandom_range(0, 7) == 0) e.dev_id = vdev_cfg;
    return e;
  endfunction

  function automatic hsc_pkg::in_item_t tick_event();
    hsc_pkg::in_item_t e;
    e = noise_event();
    e.operation = hsc_pkg::OP_TICK;
    return e;
  endfunction

  // traffic the filter must let through untouched
  function automatic hsc_pkg::in_item_t stray_event();
    hsc_pkg::in_item_t e;
    e = ptr_evt(2'($urandom), 5'($urandom));
    if ($urandom_range(0, 1) == 0) e.operation = hsc_pkg::OP_NONPTR;
    else e.dev_id = vdev_cfg;
    return e;
  endfunction

  task automatic send(input hsc_pkg::in_item_t e);
    events_to_send.push_back(e);
    queued_total++;
  endtask

  // one gesture with random content, mostly well formed, some broken or noise
  task automatic queue_gesture();
    int n;
    int h;
    h = hold_cfg;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // hold near a threshold of up to 12 ticks so some fire and some just miss; longer ones never fire
        send(ptr_evt(hsc_pkg::ACT_DOWN, press_buttons()));
        if (h > 12) n = $urandom_range(1, 6);
        else n = (h == 0 ? 1 : h) + $urandom_range(0, 2) - 1;
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) send(stray_event());
          send(tick_event());
        end
        if ($urandom_range(0, 3) == 0) send(ptr_evt(hsc_pkg::ACT_MOTION, 5'($urandom)));
        if ($urandom_range(0, 2) == 0) send(ptr_evt(hsc_pkg::ACT_UP, press_buttons()));
        send(ptr_evt(hsc_pkg::ACT_UP, release_buttons()));
      end
      3, 4: begin
        // release before the countdown runs out
        send(ptr_evt(hsc_pkg::ACT_DOWN, press_buttons()));
        n = (h > 1) ? $urandom_range(0, h > 7 ? 6 : h - 2) : 0;
        repeat (n) send(tick_event());
        send(ptr_evt(hsc_pkg::ACT_UP, release_buttons()));
      end
      5, 6: begin
        // press then drag
        send(ptr_evt(hsc_pkg::ACT_DOWN, press_buttons()));
        repeat ($urandom_range(0, 2)) send(tick_event());
        repeat ($urandom_range(1, 3)) send(ptr_evt(hsc_pkg::ACT_MOTION, 5'($urandom)));
        if ($urandom_range(0, 1) == 0) send(ptr_evt(hsc_pkg::ACT_DOWN, 5'($urandom)));
        if ($urandom_range(0, 1) == 0) send(ptr_evt(hsc_pkg::ACT_OTHER, 5'($urandom)));
        send(ptr_evt(hsc_pkg::ACT_UP, 5'($urandom)));
      end
      7: begin
        // broken sequences
        case ($urandom_range(0, 2))
          0: send(ptr_evt(hsc_pkg::ACT_UP, release_buttons()));
          1: send(ptr_evt(2'($urandom), release_buttons()));
          default: begin
            send(ptr_evt(hsc_pkg::ACT_DOWN, press_buttons()));
            send(ptr_evt(hsc_pkg::ACT_DOWN, press_buttons()));
            send(stray_event());
            send(ptr_evt(hsc_pkg::ACT_UP, release_buttons()));
          end
        endcase
      end
      default: repeat ($urandom_range(1, 4)) send(noise_event());
    endcase
  endtask

  // wait until every queued event went in and every expected result came out
  task automatic drain();
    @(posedge clk);
    while (accepted_total != queued_total || results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers, back to back, with the block idle
  task automatic write_regs(input logic [15:0] ticks, input logic [7:0] vdev);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= hsc_pkg::CFG_HOLD_TICKS;
    cfg_wdata <= ticks;
    hold_cfg = ticks;
    @(posedge clk);
    cfg_index <= hsc_pkg::CFG_VIRTUAL_DEV;
    cfg_wdata <= {8'd0, vdev};
    vdev_cfg = vdev;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic [15:0] phase_ticks [4] = '{16'd3, 16'd65535, 16'd7, 16'd1};
  logic [7:0]  phase_vdev  [4] = '{8'h5a, 8'h00, 8'ha5, 8'hff};
  int          phase_odds  [4] = '{6, 3, 10, 0};
  int          phase_start;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: hold 1000 ticks, virtual device 255
    send(mk(hsc_pkg::OP_NONPTR, hsc_pkg::ACT_OTHER, 5'h1f, 8'hff, 48'hffff_ffff_ffff,
            16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff));
    send(mk(OP_SPARE, hsc_pkg::ACT_DOWN, hsc_pkg::BTN_PRIMARY, 8'h01, 48'h1, 16'h1, 16'h1,
            16'h1, 16'h1, 16'h1));
    send(mk(hsc_pkg::OP_TICK, hsc_pkg::ACT_DOWN, '0, '0, '0, '0, '0, '0, '0, '0));
    // virtual device press is not captured
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_DOWN, hsc_pkg::BTN_PRIMARY, 8'hff, 48'h10,
            '0, '0, '0, '0, '0));
    // down without primary and a stray up in idle
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_DOWN, hsc_pkg::BTN_SECONDARY, 8'h12, 48'h20,
            16'h5, 16'h6, '0, '0, '0));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_UP, '0, 8'h12, 48'h21, '0, '0, '0, '0, '0));
    // press with extreme content, then traffic that passes while held
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_DOWN, 5'h1f, 8'h00, 48'hffff_ffff_ffff,
            16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff));
    send(mk(hsc_pkg::OP_TICK, hsc_pkg::ACT_OTHER, 5'h1f, 8'hff, 48'hffff_ffff_ffff,
            16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_DOWN, 5'h03, 8'h00, 48'h30,
            '0, '0, '0, '0, '0));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_OTHER, 5'h01, 8'h00, 48'h31,
            '0, '0, '0, '0, '0));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_UP, 5'h01, 8'h00, 48'h32, '0, '0, '0, '0, '0));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_UP, '0, 8'hff, 48'h33, '0, '0, '0, '0, '0));
    // motion while pending cancels and replays, then drag until release
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_MOTION, 5'h01, 8'h00, 48'h8000_0000_0000,
            16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h00ff));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_DOWN, 5'h02, 8'h00, 48'h41,
            '0, '0, '0, '0, '0));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_UP, 5'h01, 8'h00, 48'h42, '0, '0, '0, '0, '0));
    // early release gives a primary click
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_DOWN, hsc_pkg::BTN_PRIMARY, 8'h7e, '0,
            '0, '0, '0, '0, '0));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_UP, '0, 8'h7e, 48'h50, '0, '0, '0, '0, '0));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_DOWN, 5'h03, 8'h7e, 48'h60, 16'h10, 16'h20,
            '0, '0, 16'h1));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_UP, hsc_pkg::BTN_SECONDARY, 8'h7e, 48'h61,
            '0, '0, '0, '0, '0));
    drain();

    // zero hold fires on the first tick; old virtual id is now an ordinary device
    write_regs(16'd0, 8'd0);
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_DOWN, hsc_pkg::BTN_PRIMARY, 8'hff, 48'h70,
            16'h3, 16'h4, 16'h5, 16'h6, 16'h7));
    send(mk(hsc_pkg::OP_TICK, hsc_pkg::ACT_DOWN, '0, '0, '0, '0, '0, '0, '0, '0));
    send(mk(hsc_pkg::OP_TICK, hsc_pkg::ACT_DOWN, '0, '0, '0, '0, '0, '0, '0, '0));
    // motion after the click replays without a cancel notice
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_MOTION, hsc_pkg::BTN_PRIMARY, 8'hff, 48'h71,
            16'h9, 16'h9, '0, '0, '0));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_UP, '0, 8'hff, 48'h72, '0, '0, '0, '0, '0));
    // release after the click just passes
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_DOWN, hsc_pkg::BTN_PRIMARY, 8'h33, 48'h80,
            '0, '0, '0, '0, '0));
    send(mk(hsc_pkg::OP_TICK, hsc_pkg::ACT_DOWN, '0, '0, '0, '0, '0, '0, '0, '0));
    send(mk(hsc_pkg::OP_POINTER, hsc_pkg::ACT_UP, '0, 8'h33, 48'h81, '0, '0, '0, '0, '0));
    drain();

    // random phases; each ends with the sender waiting for every result
    for (int p = 0; p < 4; p++) begin
      write_regs(phase_ticks[p], phase_vdev[p]);
      idle_odds <= phase_odds[p];
      // long receiver hold-off while the sender keeps offering
      if (p == 1) hold_off_req <= 1'b1;
      phase_start = queued_total;
      while (queued_total - phase_start < PHASE_ITEMS) queue_gesture();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
